@@ design/lap3x3_pkg.sv @@
// Shared types and constants for the 3x3 Laplacian filter unit.
// No dependencies; used by every module of the design but lap3x3_ram.
package lap3x3_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Field widths
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 12;
    localparam int COORD_W = 11;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 13;

    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
    localparam logic [PIX_W-1:0] PIX_MAX      = PIX_W'(255);

    // Line store entry: upper row in the high byte, middle row in the low byte
    localparam int LINE_W = 2 * PIX_W;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SPARE2 = 2'd2,
        CFG_SPARE3 = 2'd3
    } cfg_idx_t;

    // Item leaving the line store stage
    typedef struct packed {
        logic               valid;
        logic               prod;   // item yields a result
        logic               calc;   // result is the filter, not a border zero
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   mid;
        logic [PIX_W-1:0]   px;
        logic [COORD_W-1:0] orow;
        logic [COORD_W-1:0] ocol;
    } s1_item_t;

endpackage

@@ design/laplacian_3x3_filter_unit.sv @@
// Top level of the 3x3 eight-neighbour Laplacian filter unit.
// Depends on lap3x3_pkg, lap3x3_front, lap3x3_back (and lap3x3_ram below them).
//
//  channel | direction | transfer when           | payload
//  s_      | in        | s_tvalid && s_tready    | tdata: pixel[7:0]; tuser: frame_start
//  m_      | out       | m_tvalid && m_tready    | tdata: out_pixel, out_row, out_col
//  cfg_    | in        | cfg_valid && cfg_ready  | cfg_index (0 width, 1 height), cfg_data
//
// One pixel per cycle unless the output stalls; a result passes the line store read,
// the window stage and the output register.
// The rate is set by the line store RAM: one read and one write-back per pixel,
// with the write forwarded when a restart reads the same column again.
// Reset clears counters, window and pipeline valids; the line store needs no clearing.
// A stalled output holds its result while the empty stages still take pixels.
module laplacian_3x3_filter_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel[7:0]
    input  logic                         s_tuser,   // frame_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // out_pixel[7:0], out_row[18:8], out_col[29:19]
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lap3x3_pkg::IDX_W-1:0] cfg_index,
    input  logic [lap3x3_pkg::DIM_W-1:0] cfg_data
);

    lap3x3_pkg::s1_item_t s1;
    logic                 s1_ready;

    lap3x3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1_ready  (s1_ready),
        .s1        (s1)
    );

    lap3x3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1),
        .s1_ready (s1_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // First pixel of a frame never yields a result
    a_frame_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s1.valid && !s1.prod)
        else $error("frame start pixel produced a result");

    // A stalled stage 1 item keeps its pixel and line data
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1.valid && !s1_ready |=> s1.valid && $stable(s1.px) && $stable(s1.mid)
                                  && $stable(s1.up))
        else $error("stage 1 item changed while stalled");

    // Nonzero filter values occur only away from the top and left border
    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[18:8] != 11'd0 && m_tdata[29:19] != 11'd0)
        else $error("nonzero result on border pixel");
`endif

endmodule

@@ design/lap3x3_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lap3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/lap3x3_front.sv @@
// Position counters, configuration registers and line store read-modify-write.
// Depends on lap3x3_pkg and lap3x3_ram.
module lap3x3_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lap3x3_pkg::PIX_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lap3x3_pkg::IDX_W-1:0] cfg_index,
    input  logic [lap3x3_pkg::DIM_W-1:0] cfg_data,
    input  logic                         s1_ready,
    output lap3x3_pkg::s1_item_t         s1
);

    localparam int CW = lap3x3_pkg::COORD_W;
    localparam int DW = lap3x3_pkg::DIM_W;
    localparam int PW = lap3x3_pkg::PIX_W;
    localparam int LW = lap3x3_pkg::LINE_W;
    localparam int AW = lap3x3_pkg::ADDR_W;

    logic [DW-1:0] width_reg, height_reg;
    logic [CW-1:0] col_reg, row_reg, col_next, row_next;
    logic [DW-1:0] w_use, h_use;
    logic          accept, restart, wrap;
    logic [CW-1:0] c, r;
    logic [DW-1:0] c_inc, r_inc;
    logic          cfg_hit;

    // Stage 1 registers
    logic          s1_valid_reg;
    logic          s1_prod_reg, s1_calc_reg;
    logic [PW-1:0] s1_px_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [CW-1:0] s1_orow_reg, s1_ocol_reg;
    logic          prod_next, calc_next;
    logic [CW-1:0] orow_next, ocol_next;

    // Forwarding of a write that lands on the address being read
    logic          fwd_hit_reg;
    logic [LW-1:0] fwd_data_reg;
    logic [LW-1:0] rd_data, line_eff, wr_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = s1_ready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == lap3x3_pkg::CFG_WIDTH ||
                        cfg_index == lap3x3_pkg::CFG_HEIGHT);

    // Dimensions saturated to the supported range
    always_comb begin
        priority if (width_reg < lap3x3_pkg::MIN_DIM) w_use = lap3x3_pkg::MIN_DIM;
        else if (width_reg > lap3x3_pkg::MAX_W_DIM)   w_use = lap3x3_pkg::MAX_W_DIM;
        else                                          w_use = width_reg;
        priority if (height_reg < lap3x3_pkg::MIN_DIM) h_use = lap3x3_pkg::MIN_DIM;
        else if (height_reg > lap3x3_pkg::MAX_H_DIM)   h_use = lap3x3_pkg::MAX_H_DIM;
        else                                           h_use = height_reg;
    end

    // Position of this pixel and of the next one
    always_comb begin
        restart  = s_tuser || ({1'b0, col_reg} >= w_use) || ({1'b0, row_reg} >= h_use);
        c        = restart ? '0 : col_reg;
        r        = restart ? '0 : row_reg;
        c_inc    = {1'b0, c} + DW'(1);
        r_inc    = {1'b0, r} + DW'(1);
        wrap     = c_inc >= w_use;
        col_next = wrap ? '0 : c_inc[CW-1:0];
        if (wrap) begin
            row_next = (r_inc >= h_use) ? '0 : r_inc[CW-1:0];
        end else begin
            row_next = r;
        end
    end

    // Result classification: interior, top or left border, or trailing right border
    always_comb begin
        prod_next = 1'b0;
        calc_next = 1'b0;
        orow_next = '0;
        ocol_next = '0;
        priority if (c != '0 && r != '0) begin
            prod_next = 1'b1;
            calc_next = (r >= CW'(2)) && (c >= CW'(2));
            orow_next = r - CW'(1);
            ocol_next = c - CW'(1);
        end else if (c == '0 && r >= CW'(2)) begin
            prod_next = 1'b1;
            orow_next = r - CW'(2);
            ocol_next = CW'(w_use - DW'(1));
        end else begin
            prod_next = 1'b0;
        end
    end

    // Config registers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lap3x3_pkg::RESET_WIDTH;
            height_reg <= lap3x3_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index == lap3x3_pkg::CFG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && cfg_index == lap3x3_pkg::CFG_HEIGHT) begin
                height_reg <= cfg_data;
            end
            priority if (cfg_hit) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= accept;
            end
            if (accept) begin
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == c[AW-1:0]);
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg    <= s_tdata;
            s1_addr_reg  <= c[AW-1:0];
            s1_prod_reg  <= prod_next;
            s1_calc_reg  <= calc_next;
            s1_orow_reg  <= orow_next;
            s1_ocol_reg  <= ocol_next;
            fwd_data_reg <= wr_data;
        end
    end

    // Line store: read at acceptance, write back when stage 1 moves on
    assign line_eff = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_data  = {line_eff[PW-1:0], s1_px_reg};

    lap3x3_ram #(
        .WIDTH (LW),
        .DEPTH (lap3x3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg && s1_ready),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (c[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        s1.valid = s1_valid_reg;
        s1.prod  = s1_prod_reg;
        s1.calc  = s1_calc_reg;
        s1.up    = line_eff[LW-1:PW];
        s1.mid   = line_eff[PW-1:0];
        s1.px    = s1_px_reg;
        s1.orow  = s1_orow_reg;
        s1.ocol  = s1_ocol_reg;
    end

endmodule

@@ design/lap3x3_back.sv @@
// 3x3 window, Laplacian sum with clamp, and the output register.
// Depends on lap3x3_pkg.
module lap3x3_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lap3x3_pkg::s1_item_t s1,
    output logic                 s1_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata   // out_pixel[7:0], out_row[18:8], out_col[29:19]
);

    localparam int CW = lap3x3_pkg::COORD_W;
    localparam int PW = lap3x3_pkg::PIX_W;
    localparam int SW = lap3x3_pkg::SUM_W;

    logic [PW-1:0] win_reg [9];
    logic          s2_valid_reg, s2_prod_reg, s2_calc_reg;
    logic [CW-1:0] s2_orow_reg, s2_ocol_reg;
    logic          m_tvalid_reg;
    logic [PW-1:0] out_pixel_reg;
    logic [CW-1:0] out_row_reg, out_col_reg;
    logic          s2_ready, out_hold;
    logic signed [SW-1:0] acc;
    logic [SW-1:0]        nsum;
    logic [PW-1:0]        val;

    // Pipeline enables
    assign out_hold = m_tvalid_reg && !m_tready;
    assign s2_ready = !s2_valid_reg || !s2_prod_reg || !out_hold;
    assign s1_ready = !s1.valid || s2_ready;

    // Window shift and stage 2 metadata
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1.valid && s1_ready) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= s1.up;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= s1.mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1.px;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1.valid && s1_ready) begin
            s2_prod_reg <= s1.prod;
            s2_calc_reg <= s1.calc;
            s2_orow_reg <= s1.orow;
            s2_ocol_reg <= s1.ocol;
        end
    end

    // Eight times the centre minus the neighbours, clamped to a byte
    always_comb begin
        nsum = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nsum = nsum + SW'(win_reg[i]);
            end
        end
        acc = $signed({2'b00, win_reg[4], 3'b000}) - $signed(nsum);
        priority if (acc < 0)                      val = '0;
        else if (acc > $signed(SW'(lap3x3_pkg::PIX_MAX))) val = lap3x3_pkg::PIX_MAX;
        else                                       val = acc[PW-1:0];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!out_hold) begin
            m_tvalid_reg <= s2_valid_reg && s2_prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_hold && s2_valid_reg && s2_prod_reg) begin
            out_pixel_reg <= s2_calc_reg ? val : '0;
            out_row_reg   <= s2_orow_reg;
            out_col_reg   <= s2_ocol_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_pixel_reg};

endmodule

@@ verif/laplacian_3x3_filter_unit_test.sv @@
// Self-checking testbench for laplacian_3x3_filter_unit: directed and random pixel streams,
// each result checked field by field against an in-bench model of the 3x3 Laplacian.
// Depends on lap3x3_pkg and the filter unit RTL.
module laplacian_3x3_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS  = 950;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int BIG_RUN        = 160;

    typedef struct {
        logic [lap3x3_pkg::PIX_W-1:0] pixel;
        logic                         frame_start;
    } pixel_item_t;

    // Same bit order as m_tdata[29:0]
    typedef struct packed {
        logic [lap3x3_pkg::COORD_W-1:0] col;
        logic [lap3x3_pkg::COORD_W-1:0] row;
        logic [lap3x3_pkg::PIX_W-1:0]   value;
    } lap_result_t;

    // DUT ports; the inputs are known from time zero
    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata   = '0;    // pixel[7:0]
    logic                         s_tuser   = 1'b0;  // frame_start
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [31:0]                  m_tdata;           // out_pixel[7:0], out_row[18:8], out_col[29:19]
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    lap3x3_pkg::cfg_idx_t         cfg_index = lap3x3_pkg::CFG_WIDTH;
    logic [lap3x3_pkg::DIM_W-1:0] cfg_data  = '0;

    // Bench state
    pixel_item_t   pixel_feed[$];
    lap_result_t   owed_results[$];
    logic          in_taken  = 1'b0;
    logic          cfg_taken = 1'b0;
    bit            src_idle_en = 1'b1;
    bit            snk_idle_en = 1'b1;
    int unsigned   src_gap = 0;
    int unsigned   snk_gap = 0;
    int unsigned   n_bad = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   pix_style = 0;
    int unsigned   pix_base = 0;

    // Filter model state
    logic [lap3x3_pkg::DIM_W-1:0] width_reg;
    logic [lap3x3_pkg::DIM_W-1:0] height_reg;
    logic [lap3x3_pkg::PIX_W-1:0] upper_line [lap3x3_pkg::MAX_WIDTH];
    logic [lap3x3_pkg::PIX_W-1:0] middle_line [lap3x3_pkg::MAX_WIDTH];
    logic [lap3x3_pkg::PIX_W-1:0] win [9];
    int unsigned                  next_row;
    int unsigned                  next_col;

    laplacian_3x3_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Dimension in use: register saturated to 3..limit
    function automatic int unsigned used_dim(logic [lap3x3_pkg::DIM_W-1:0] v,
                                             int unsigned limit);
        if (v < 3) return 3;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    function automatic void laplace_reset();
        width_reg  = lap3x3_pkg::RESET_WIDTH;
        height_reg = lap3x3_pkg::RESET_HEIGHT;
        for (int i = 0; i < lap3x3_pkg::MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        next_row = 0;
        next_col = 0;
    endfunction

    // Width/height writes restart the frame; spare indexes do nothing
    function automatic void laplace_set_reg(lap3x3_pkg::cfg_idx_t idx,
                                            logic [lap3x3_pkg::DIM_W-1:0] v);
        case (idx)
            lap3x3_pkg::CFG_WIDTH: begin
                width_reg = v;
                next_row  = 0;
                next_col  = 0;
            end
            lap3x3_pkg::CFG_HEIGHT: begin
                height_reg = v;
                next_row   = 0;
                next_col   = 0;
            end
            default: ;
        endcase
    endfunction

    // One accepted pixel: update line stores and window, queue the result it owes
    function automatic void laplace_step(logic [lap3x3_pkg::PIX_W-1:0] px, logic fs);
        int unsigned w, h, r, c;
        logic [lap3x3_pkg::PIX_W-1:0] up, mid;
        int acc;
        lap_result_t res;
        bit produced;
        w = used_dim(width_reg, lap3x3_pkg::MAX_WIDTH);
        h = used_dim(height_reg, lap3x3_pkg::MAX_HEIGHT);
        if (fs || next_col >= w || next_row >= h) begin
            next_row = 0;
            next_col = 0;
        end
        r = next_row;
        c = next_col;

        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;

        win[0] = win[1]; win[1] = win[2]; win[2] = up;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;

        produced = 1'b0;
        res = '0;
        if (c >= 1 && r >= 1) begin
            produced = 1'b1;
            res.row  = lap3x3_pkg::COORD_W'(r - 1);
            res.col  = lap3x3_pkg::COORD_W'(c - 1);
            if (r >= 2 && c >= 2) begin
                acc = 8 * int'(win[4]);
                for (int k = 0; k < 9; k++)
                    if (k != 4) acc -= int'(win[k]);
                if (acc > int'(lap3x3_pkg::PIX_MAX)) acc = int'(lap3x3_pkg::PIX_MAX);
                if (acc < 0) acc = 0;
                res.value = lap3x3_pkg::PIX_W'(acc);
            end
        end else if (c == 0 && r >= 2) begin
            // left edge of a new row closes the right border of the row two up
            produced = 1'b1;
            res.row  = lap3x3_pkg::COORD_W'(r - 2);
            res.col  = lap3x3_pkg::COORD_W'(w - 1);
        end
        if (produced) owed_results.push_back(res);

        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endfunction

    function automatic void check_result(logic [31:0] data);
        lap_result_t got, want;
        got = data[29:0];
        if (owed_results.size() == 0) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
                $display("unexpected result: pixel %0d row %0d col %0d",
                         got.value, got.row, got.col);
        end else begin
            want = owed_results.pop_front();
            if (got.value !== want.value || got.row !== want.row || got.col !== want.col) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("mismatch: expected pixel %0d row %0d col %0d, got pixel %0d row %0d col %0d",
                             want.value, want.row, want.col, got.value, got.row, got.col);
            end
        end
    endfunction

    // Monitor: every transfer seen at the rising edge
    always @(posedge aclk) begin
        in_taken  <= aresetn && s_tvalid && s_tready;
        cfg_taken <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) laplace_set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) laplace_step(s_tdata, s_tuser);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pixel driver: holds an item until its transfer, idles in bursts between items
    always @(negedge aclk) begin
        pixel_item_t item;
        if (!s_tvalid || in_taken) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end else if (pixel_feed.size() != 0) begin
                item = pixel_feed.pop_front();
                s_tdata  <= item.pixel;
                s_tuser  <= item.frame_start;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: ready with random stall bursts
    always @(negedge aclk) begin
        if (snk_gap != 0) begin
            snk_gap = snk_gap - 1;
            m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void push_pixel(logic [lap3x3_pkg::PIX_W-1:0] px, logic fs);
        pixel_item_t item;
        item.pixel       = px;
        item.frame_start = fs;
        pixel_feed.push_back(item);
    endfunction

    // Pixel content per frame style: uniform, smooth around a base, or black/white only
    function automatic logic [lap3x3_pkg::PIX_W-1:0] next_pixel();
        int v;
        case (pix_style)
            1: begin
                v = int'(pix_base) + $urandom_range(0, 16) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return lap3x3_pkg::PIX_W'(v);
            end
            2: return $urandom_range(0, 1) ? lap3x3_pkg::PIX_MAX : '0;
            default: return lap3x3_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue a run of pixels; frame_start on the first one if asked, else at random odds
    function automatic int unsigned queue_run(int unsigned count, bit first_fs,
                                              int unsigned fs_odds);
        logic fs;
        pix_style = $urandom_range(0, 2);
        pix_base  = $urandom_range(0, 255);
        for (int unsigned i = 0; i < count; i++) begin
            fs = (i == 0) ? first_fs : (fs_odds != 0 && $urandom_range(1, fs_odds) == 1);
            push_pixel(next_pixel(), fs);
        end
        return count;
    endfunction

    // 3x3 test patch: a ring value around a centre value
    function automatic void queue_patch(int unsigned first, int unsigned last,
                                        logic [lap3x3_pkg::PIX_W-1:0] ring,
                                        logic [lap3x3_pkg::PIX_W-1:0] centre,
                                        bit fs);
        for (int unsigned i = first; i <= last; i++)
            push_pixel(i == 4 ? centre : ring, fs && i == 0);
    endfunction

    function automatic logic [lap3x3_pkg::DIM_W-1:0] pick_dim(int unsigned hi, bit big_ok);
        case ($urandom_range(0, 19))
            0, 1: return lap3x3_pkg::DIM_W'($urandom_range(0, 2));
            2: return big_ok ? lap3x3_pkg::DIM_W'($urandom_range(lap3x3_pkg::MAX_HEIGHT, 4095))
                             : lap3x3_pkg::DIM_W'(3);
            default: return lap3x3_pkg::DIM_W'($urandom_range(3, hi));
        endcase
    endfunction

    // Wait until all pixels are in and all results out, then let the pipeline empty
    task automatic settle();
        while (pixel_feed.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(lap3x3_pkg::cfg_idx_t idx, logic [lap3x3_pkg::DIM_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_taken) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned n_random, w, h, total, kind;
        logic [lap3x3_pkg::DIM_W-1:0] wcfg, hcfg;
        laplace_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: smallest frame, clamping both ways, wrap, restarts
        write_reg(lap3x3_pkg::CFG_WIDTH, lap3x3_pkg::DIM_W'(3));
        write_reg(lap3x3_pkg::CFG_HEIGHT, lap3x3_pkg::DIM_W'(3));
        queue_patch(0, 8, '0, lap3x3_pkg::PIX_MAX, 1'b1);       // clamps high
        queue_patch(0, 8, lap3x3_pkg::PIX_MAX, '0, 1'b0);       // wraps without frame_start
        queue_patch(0, 3, lap3x3_pkg::PIX_W'(90), lap3x3_pkg::PIX_W'(100), 1'b1);
        settle();
        // spare register writes must not restart the frame
        write_reg(lap3x3_pkg::CFG_SPARE2, '1);
        write_reg(lap3x3_pkg::CFG_SPARE3, lap3x3_pkg::DIM_W'(12'h555));
        queue_patch(4, 8, lap3x3_pkg::PIX_W'(90), lap3x3_pkg::PIX_W'(100), 1'b0);
        push_pixel(lap3x3_pkg::PIX_W'(7), 1'b1);                // back-to-back restarts
        push_pixel(lap3x3_pkg::PIX_W'(9), 1'b1);
        settle();

        // Random phases, one setting each
        n_random = 0;
        while (n_random < RANDOM_PIXELS) begin
            wcfg = pick_dim(24, 1'b0);
            hcfg = pick_dim(10, 1'b1);
            write_reg(lap3x3_pkg::CFG_WIDTH, wcfg);
            if ($urandom_range(0, 4) != 0) write_reg(lap3x3_pkg::CFG_HEIGHT, hcfg);
            w = used_dim(width_reg, lap3x3_pkg::MAX_WIDTH);
            h = used_dim(height_reg, lap3x3_pkg::MAX_HEIGHT);
            total = (w * h > 400) ? 0 : w * h;
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                if (total == 0)
                    n_random += queue_run($urandom_range(1, 300), 1'b1, 0);
                else if (kind <= 6)
                    n_random += queue_run(total, 1'b1, 0);
                else if (kind == 7)
                    n_random += queue_run($urandom_range(1, total - 1), 1'b1, 0);
                else if (kind == 8)
                    n_random += queue_run(total, 1'b0, 0);
                else
                    n_random += queue_run($urandom_range(1, 2 * w),
                                          1'($urandom_range(0, 1)), 8);
            end
            settle();
        end

        // Largest dimensions: all register bits set, saturating to the maximum;
        // less than one row goes in, so no result is owed
        write_reg(lap3x3_pkg::CFG_WIDTH, '1);
        write_reg(lap3x3_pkg::CFG_HEIGHT, '1);
        void'(queue_run(BIG_RUN, 1'b1, 0));
        settle();

        // Closing stretch without idling
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        write_reg(lap3x3_pkg::CFG_WIDTH, lap3x3_pkg::DIM_W'($urandom_range(3, 16)));
        write_reg(lap3x3_pkg::CFG_HEIGHT, lap3x3_pkg::DIM_W'($urandom_range(3, 8)));
        w = used_dim(width_reg, lap3x3_pkg::MAX_WIDTH);
        h = used_dim(height_reg, lap3x3_pkg::MAX_HEIGHT);
        void'(queue_run(w * h, 1'b1, 0));
        void'(queue_run(w * h, 1'b1, 0));

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (n_bad == 0 && owed_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
